// ===== rtl/bcs_pkg.sv =====
// Package for the bit map unit: command codes, item structs, sequencer
// states and small byte helpers. No dependencies.

package bcs_pkg;

  localparam int MaxBitsDef     = 8192;
  localparam int BitsInUseReset = 8192;

  typedef enum logic [3:0] {
    CmdTest     = 4'd0,
    CmdSet      = 4'd1,
    CmdClear    = 4'd2,
    CmdSetAll   = 4'd3,
    CmdClearAll = 4'd4,
    CmdInvert   = 4'd5,
    CmdLoad     = 4'd6,
    CmdOr       = 4'd7,
    CmdAnd      = 4'd8,
    CmdExcept   = 4'd9,
    CmdRead     = 4'd10,
    CmdSelect   = 4'd11
  } cmd_e;

  typedef struct packed {
    logic [3:0]  command;
    logic [12:0] bit_index;
    logic [9:0]  byte_index;
    logic [7:0]  byte_value;
    logic [12:0] rank;
  } in_item_t;

  typedef struct packed {
    logic        bit_value;
    logic [7:0]  byte_data;
    logic [12:0] found_index;
    logic [13:0] set_count;
    logic        is_full;
    logic        is_empty;
    logic        rejected;
  } out_item_t;

  typedef enum logic [2:0] {
    StIdle,
    StExec,
    StSweep,
    StSelect,
    StFinish
  } state_e;

  typedef enum logic [1:0] {
    OpTrim,
    OpZero,
    OpOnes,
    OpInvert
  } sweep_op_e;

  function automatic logic [3:0] popcount8(input logic [7:0] b);
    logic [3:0] n;
    n = '0;
    for (int j = 0; j < 8; j++) begin
      n = n + {3'b000, b[j]};
    end
    return n;
  endfunction

  // MSB-first bit order: offset 0 is bit 7
  function automatic logic [7:0] bit_mask(input logic [2:0] ofs);
    return 8'h80 >> ofs;
  endfunction

  // offset of the r-th set bit, counted from the MSB
  function automatic logic [2:0] sel_pos(input logic [7:0] b, input logic [2:0] r);
    logic [3:0] cnt;
    logic       hit;
    logic [2:0] pos;
    cnt = '0;
    hit = 1'b0;
    pos = '0;
    for (int j = 0; j < 8; j++) begin
      if (b[7-j]) begin
        if (!hit && cnt == {1'b0, r}) begin
          pos = 3'(j);
          hit = 1'b1;
        end
        cnt = cnt + 4'd1;
      end
    end
    return pos;
  endfunction

endpackage

// ===== rtl/bcs_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read
// with read enable. No dependencies.

module bcs_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/bitmap_with_count_and_select_unit.sv =====
// Top level of the bit map unit with running set-bit count and rank select.
// Depends on bcs_pkg and bcs_ram.

// The map sits in one byte-wide RAM of (MaxBits+7)/8 entries, MSB-first, next
// to a register holding the set-bit count. Test, set, clear and the byte
// commands do one RAM read at acceptance, then the write-back and the result
// once the output register is free. Set all, clear all and invert sweep the
// whole RAM one byte a cycle through the single read and write port. A write
// of bits_in_use starts the same sweep, trimming pad bits and recounting;
// items are stalled while it runs. Select reads bytes from the start until
// the rank falls in one. After reset a clearing pass over the whole RAM runs
// before the first item is taken. A result waiting in the output register
// does not block the next item from entering.

module bitmap_with_count_and_select_unit
  import bcs_pkg::*;
#(
  parameter int MaxBits = MaxBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [13:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_item_o
);

  localparam int StoreBytes = (MaxBits + 7) / 8;
  localparam int AddrW      = (StoreBytes > 1) ? $clog2(StoreBytes) : 1;
  localparam int CntW0      = $clog2(MaxBits + 8);
  localparam int CW         = (CntW0 > 14) ? CntW0 : 14;

  localparam logic [CW-1:0]  MaxBitsC    = CW'(MaxBits);
  localparam logic [CW-1:0]  BiuReset    = (MaxBits < BitsInUseReset) ?
                                           CW'(MaxBits) : CW'(BitsInUseReset);
  localparam logic [AddrW:0] StoreBytesC = (AddrW + 1)'(StoreBytes);

  function automatic logic [7:0] valid_mask(input logic [AddrW-1:0] a,
                                            input logic [CW-1:0]    nb,
                                            input logic [2:0]       rem);
    logic [CW-1:0] ax;
    logic [7:0]    m;
    ax = CW'(a);
    if (ax >= nb) begin
      m = 8'h00;
    end else if ((ax + CW'(1)) == nb && rem != 3'd0) begin
      m = ~(8'hff >> rem);
    end else begin
      m = 8'hff;
    end
    return m;
  endfunction

  // control state
  state_e          state_q, state_d;
  sweep_op_e       op_q, op_d;
  logic            sweep_out_q, sweep_out_d;
  logic [AddrW:0]  cnt_q, cnt_d;
  logic            dat_pend_q, dat_pend_d;
  logic [CW-1:0]   total_q, total_d;
  logic [CW-1:0]   biu_q, biu_d;
  logic            out_valid_q, out_valid_d;

  // item payload
  logic [3:0]       cmd_q, cmd_d;
  logic [AddrW-1:0] addr_q, addr_d;
  logic [AddrW-1:0] dat_addr_q, dat_addr_d;
  logic [2:0]       bofs_q, bofs_d;
  logic [7:0]       yv_q, yv_d;
  logic             rej_q, rej_d;
  logic [12:0]      rank_q, rank_d;
  logic [12:0]      found_q, found_d;
  out_item_t        out_q, out_d;

  // RAM port
  logic             rd_en, wr_en;
  logic [AddrW-1:0] rd_addr, wr_addr;
  logic [7:0]       wr_data, rd_data;

  // decoded
  logic [CW-1:0]    nb_c;
  logic [2:0]       rem_c;
  logic             in_acc, out_free, rd_more, sweep_done, hit;
  logic [CW-1:0]    bi_ext, yi_ext, rk_ext, cfg_ext, cfg_clamp;
  logic             acc_rej;
  logic [AddrW-1:0] acc_addr;
  state_e           acc_state;
  sweep_op_e        acc_op;
  logic [7:0]       cur, ex_raw, ex_new, sw_raw, sw_new;
  logic [3:0]       pop_cur, pop_ex, pop_sw;
  logic             ex_write;
  logic [CW-1:0]    ex_total, fnd;

  bcs_ram #(
    .Width(8),
    .Depth(StoreBytes),
    .AddrW(AddrW)
  ) u_store (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  assign nb_c       = (biu_q + CW'(7)) >> 3;
  assign rem_c      = biu_q[2:0];
  assign in_stall_o = (state_q != StIdle) || cfg_we_i;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign rd_more    = cnt_q < StoreBytesC;
  assign sweep_done = !rd_more && !dat_pend_q;
  assign cur        = rd_data;
  assign pop_cur    = popcount8(cur);
  assign hit        = dat_pend_q && (13'(pop_cur) > rank_q);

  assign cfg_ext = CW'(cfg_wdata_i);
  always_comb begin
    cfg_clamp = cfg_ext;
    if (cfg_ext == '0) begin
      cfg_clamp = CW'(1);
    end
    if (cfg_ext > MaxBitsC) begin
      cfg_clamp = MaxBitsC;
    end
  end

  // item decode at acceptance
  assign bi_ext = CW'(in_item_i.bit_index);
  assign yi_ext = CW'(in_item_i.byte_index);
  assign rk_ext = CW'(in_item_i.rank);

  always_comb begin
    acc_rej   = 1'b0;
    acc_addr  = yi_ext[AddrW-1:0];
    acc_state = StExec;
    acc_op    = OpTrim;
    case (in_item_i.command)
      CmdTest, CmdSet, CmdClear: begin
        acc_rej  = bi_ext >= biu_q;
        acc_addr = bi_ext[AddrW+2:3];
      end
      CmdSetAll: begin
        acc_state = StSweep;
        acc_op    = OpOnes;
      end
      CmdClearAll: begin
        acc_state = StSweep;
        acc_op    = OpZero;
      end
      CmdInvert: begin
        acc_state = StSweep;
        acc_op    = OpInvert;
      end
      CmdLoad, CmdOr, CmdAnd, CmdExcept, CmdRead: begin
        acc_rej = yi_ext >= nb_c;
      end
      CmdSelect: begin
        acc_rej = rk_ext >= total_q;
        if (!acc_rej) begin
          acc_state = StSelect;
        end
      end
      default: begin
        acc_rej = 1'b1;
      end
    endcase
  end

  // single byte read-modify-write
  always_comb begin
    ex_raw   = cur;
    ex_write = 1'b0;
    case (cmd_q)
      CmdSet: begin
        ex_raw   = cur | bit_mask(bofs_q);
        ex_write = 1'b1;
      end
      CmdClear: begin
        ex_raw   = cur & ~bit_mask(bofs_q);
        ex_write = 1'b1;
      end
      CmdLoad: begin
        ex_raw   = yv_q;
        ex_write = 1'b1;
      end
      CmdOr: begin
        ex_raw   = cur | yv_q;
        ex_write = 1'b1;
      end
      CmdAnd: begin
        ex_raw   = cur & yv_q;
        ex_write = 1'b1;
      end
      CmdExcept: begin
        ex_raw   = cur & ~yv_q;
        ex_write = 1'b1;
      end
      default: begin
        ex_raw   = cur;
        ex_write = 1'b0;
      end
    endcase
  end

  assign ex_new   = ex_raw & valid_mask(addr_q, nb_c, rem_c);
  assign pop_ex   = popcount8(ex_new);
  assign ex_total = (ex_write && !rej_q) ?
                    (total_q - CW'(pop_cur) + CW'(pop_ex)) : total_q;

  // whole-store sweep byte
  always_comb begin
    case (op_q)
      OpTrim:   sw_raw = cur;
      OpZero:   sw_raw = 8'h00;
      OpOnes:   sw_raw = 8'hff;
      OpInvert: sw_raw = ~cur;
      default:  sw_raw = 8'h00;
    endcase
  end

  assign sw_new = sw_raw & valid_mask(dat_addr_q, nb_c, rem_c);
  assign pop_sw = popcount8(sw_new);
  assign fnd    = (CW'(dat_addr_q) << 3) | CW'(sel_pos(cur, rank_q[2:0]));

  // next state
  always_comb begin
    state_d = state_q;
    if (cfg_we_i) begin
      state_d = StSweep;
    end else begin
      case (state_q)
        StIdle:   if (in_acc) state_d = acc_state;
        StExec:   if (out_free) state_d = StIdle;
        StSweep:  if (sweep_done) state_d = sweep_out_q ? StFinish : StIdle;
        StSelect: if (hit) state_d = StFinish;
        StFinish: if (out_free) state_d = StIdle;
        default:  state_d = StIdle;
      endcase
    end
  end

  // datapath and outputs
  always_comb begin
    op_d        = op_q;
    sweep_out_d = sweep_out_q;
    cnt_d       = cnt_q;
    dat_pend_d  = dat_pend_q;
    dat_addr_d  = dat_addr_q;
    total_d     = total_q;
    biu_d       = biu_q;
    cmd_d       = cmd_q;
    addr_d      = addr_q;
    bofs_d      = bofs_q;
    yv_d        = yv_q;
    rej_d       = rej_q;
    rank_d      = rank_q;
    found_d     = found_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    rd_en       = 1'b0;
    rd_addr     = cnt_q[AddrW-1:0];
    wr_en       = 1'b0;
    wr_addr     = dat_addr_q;
    wr_data     = sw_new;

    if (cfg_we_i) begin
      biu_d       = cfg_clamp;
      op_d        = (state_q == StSweep && op_q == OpZero) ? OpZero : OpTrim;
      sweep_out_d = 1'b0;
      cnt_d       = '0;
      dat_pend_d  = 1'b0;
      total_d     = '0;
    end else begin
      case (state_q)
        StIdle: begin
          if (in_acc) begin
            rd_en       = 1'b1;
            rd_addr     = acc_addr;
            cmd_d       = in_item_i.command;
            addr_d      = acc_addr;
            bofs_d      = in_item_i.bit_index[2:0];
            yv_d        = in_item_i.byte_value;
            rej_d       = acc_rej;
            rank_d      = in_item_i.rank;
            found_d     = '0;
            op_d        = acc_op;
            sweep_out_d = 1'b1;
            cnt_d       = '0;
            dat_pend_d  = 1'b0;
            if (acc_state == StSweep) begin
              total_d = '0;
            end
          end
        end
        StExec: begin
          if (out_free) begin
            wr_en   = ex_write && !rej_q;
            wr_addr = addr_q;
            wr_data = ex_new;
            total_d = ex_total;
            out_d.bit_value   = (cmd_q == CmdTest && !rej_q) ?
                                |(cur & bit_mask(bofs_q)) : 1'b0;
            out_d.byte_data   = (cmd_q == CmdRead && !rej_q) ? cur : 8'h00;
            out_d.found_index = '0;
            out_d.set_count   = ex_total[13:0];
            out_d.is_full     = ex_total >= biu_q;
            out_d.is_empty    = ex_total == '0;
            out_d.rejected    = rej_q;
            out_valid_d       = 1'b1;
          end
        end
        StSweep: begin
          rd_en      = rd_more;
          cnt_d      = rd_more ? (cnt_q + (AddrW + 1)'(1)) : cnt_q;
          dat_pend_d = rd_more;
          dat_addr_d = cnt_q[AddrW-1:0];
          if (dat_pend_q) begin
            wr_en   = 1'b1;
            total_d = total_q + CW'(pop_sw);
          end
        end
        StSelect: begin
          rd_en      = rd_more;
          cnt_d      = rd_more ? (cnt_q + (AddrW + 1)'(1)) : cnt_q;
          dat_pend_d = rd_more;
          dat_addr_d = cnt_q[AddrW-1:0];
          if (dat_pend_q) begin
            if (hit) begin
              found_d = fnd[12:0];
            end else begin
              rank_d = rank_q - 13'(pop_cur);
            end
          end
        end
        StFinish: begin
          if (out_free) begin
            out_d.bit_value   = 1'b0;
            out_d.byte_data   = 8'h00;
            out_d.found_index = found_q;
            out_d.set_count   = total_q[13:0];
            out_d.is_full     = total_q >= biu_q;
            out_d.is_empty    = total_q == '0;
            out_d.rejected    = 1'b0;
            out_valid_d       = 1'b1;
          end
        end
        default: begin
          cnt_d = cnt_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StSweep;
      op_q        <= OpZero;
      sweep_out_q <= 1'b0;
      cnt_q       <= '0;
      dat_pend_q  <= 1'b0;
      total_q     <= '0;
      biu_q       <= BiuReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      sweep_out_q <= sweep_out_d;
      cnt_q       <= cnt_d;
      dat_pend_q  <= dat_pend_d;
      total_q     <= total_d;
      biu_q       <= biu_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    addr_q     <= addr_d;
    dat_addr_q <= dat_addr_d;
    bofs_q     <= bofs_d;
    yv_q       <= yv_d;
    rej_q      <= rej_d;
    rank_q     <= rank_d;
    found_q    <= found_d;
    out_q      <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== sim/tb_bitmap_with_count_and_select_unit.sv =====
// Testbench for bitmap_with_count_and_select_unit: directed and random commands under random
// stalls, checked item by item against a bit map mirror held in a scoreboard class.
// Depends on bcs_pkg and the unit RTL.

import bcs_pkg::*;

class bitmap_mirror;
  localparam int unsigned StoreBytes = (MaxBitsDef + 7) / 8;

  logic [7:0]  map_bytes [StoreBytes];
  int unsigned ones_total;
  int unsigned width_bits;
  out_item_t   expected_resp [$];
  int          errors;

  function new();
    foreach (map_bytes[k]) map_bytes[k] = 8'h00;
    ones_total = 0;
    width_bits = BitsInUseReset;
    errors     = 0;
  endfunction

  function int unsigned byte_span();
    return (width_bits + 7) / 8;
  endfunction

  // pad bits of the last byte are masked off
  function logic [7:0] keep_mask(int unsigned k);
    int unsigned r;
    r = width_bits % 8;
    if (k + 1 == byte_span() && r != 0) return ~(8'hff >> r);
    return 8'hff;
  endfunction

  function void trim_recount();
    ones_total = 0;
    foreach (map_bytes[k]) begin
      if (k < byte_span()) map_bytes[k] = map_bytes[k] & keep_mask(k);
      else map_bytes[k] = 8'h00;
      ones_total += $countones(map_bytes[k]);
    end
  endfunction

  function void resize(logic [13:0] v);
    if (v == 0) width_bits = 1;
    else if (v > MaxBitsDef) width_bits = MaxBitsDef;
    else width_bits = v;
    trim_recount();
  endfunction

  function void put_byte(int unsigned k, logic [7:0] nv);
    nv = nv & keep_mask(k);
    ones_total = ones_total - $countones(map_bytes[k]) + $countones(nv);
    map_bytes[k] = nv;
  endfunction

  function void note_command(in_item_t it);
    out_item_t   res;
    int unsigned bi, yi, left;
    logic [7:0]  cur, msk;
    res = '0;
    bi  = it.bit_index;
    yi  = it.byte_index;
    case (it.command)
      CmdTest, CmdSet, CmdClear: begin
        if (bi >= width_bits) begin
          res.rejected = 1'b1;
        end else begin
          cur = map_bytes[bi / 8];
          msk = 8'h80 >> (bi % 8);
          if (it.command == CmdTest) res.bit_value = |(cur & msk);
          else if (it.command == CmdSet) put_byte(bi / 8, cur | msk);
          else put_byte(bi / 8, cur & ~msk);
        end
      end
      CmdSetAll, CmdClearAll, CmdInvert: begin
        for (int unsigned k = 0; k < byte_span(); k++) begin
          if (it.command == CmdSetAll) map_bytes[k] = 8'hff;
          else if (it.command == CmdClearAll) map_bytes[k] = 8'h00;
          else map_bytes[k] = ~map_bytes[k];
        end
        trim_recount();
      end
      CmdLoad, CmdOr, CmdAnd, CmdExcept, CmdRead: begin
        if (yi >= byte_span()) begin
          res.rejected = 1'b1;
        end else begin
          cur = map_bytes[yi];
          case (it.command)
            CmdLoad:   put_byte(yi, it.byte_value);
            CmdOr:     put_byte(yi, cur | it.byte_value);
            CmdAnd:    put_byte(yi, cur & it.byte_value);
            CmdExcept: put_byte(yi, cur & ~it.byte_value);
            default:   res.byte_data = cur;
          endcase
        end
      end
      CmdSelect: begin
        if (it.rank >= ones_total) begin
          res.rejected = 1'b1;
        end else begin
          left = it.rank;
          for (int unsigned i = 0; i < width_bits; i++) begin
            if (map_bytes[i / 8][7 - (i % 8)]) begin
              if (left == 0) begin
                res.found_index = 13'(i);
                break;
              end
              left--;
            end
          end
        end
      end
      default: res.rejected = 1'b1;
    endcase
    res.set_count = 14'(ones_total);
    res.is_full   = ones_total >= width_bits;
    res.is_empty  = ones_total == 0;
    expected_resp.push_back(res);
  endfunction

  task report(string what, int unsigned got, int unsigned want);
    if (errors < 50) $display("%0t mismatch %s: got %0h, expected %0h", $time, what, got, want);
    errors++;
  endtask

  task check_response(out_item_t got);
    out_item_t want;
    if (expected_resp.size() == 0) begin
      report("item with none expected", 32'(got), 0);
      return;
    end
    want = expected_resp.pop_front();
    if (got.bit_value != want.bit_value) report("bit_value", got.bit_value, want.bit_value);
    if (got.byte_data != want.byte_data) report("byte_data", got.byte_data, want.byte_data);
    if (got.found_index != want.found_index)
      report("found_index", got.found_index, want.found_index);
    if (got.set_count != want.set_count) report("set_count", got.set_count, want.set_count);
    if (got.is_full != want.is_full) report("is_full", got.is_full, want.is_full);
    if (got.is_empty != want.is_empty) report("is_empty", got.is_empty, want.is_empty);
    if (got.rejected != want.rejected) report("rejected", got.rejected, want.rejected);
  endtask
endclass

module tb_bitmap_with_count_and_select_unit;

  localparam logic [3:0] CmdUnusedFirst = 4'd12;
  localparam logic [3:0] CmdUnusedLast  = 4'd15;
  localparam int         PhaseItems     = 127;
  localparam int         HoldCycles     = 400;
  localparam int         TailCycles     = 1100;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [13:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  in_item_t    in_item_i;
  logic        out_valid_o;
  logic        out_stall_i = 1'b1;
  out_item_t   out_item_o;

  bitmap_mirror mirror = new();

  int   send_idle = 22;
  int   recv_idle = 65;
  logic hold_tog  = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;

  int unsigned phase_size [12] = '{1, 0, 16383, 8192, 9, 64, 8191, 100, 13, 2047, 37, 256};

  bitmap_with_count_and_select_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always #5 clk_i = ~clk_i;

  // receiver: random stalls, or a long hold-off when requested
  always @(negedge clk_i) begin
    if (hold_tog != hold_seen) begin
      hold_seen   <= hold_tog;
      hold_left   <= HoldCycles;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) mirror.check_response(out_item_o);
  end

  function automatic in_item_t mk(logic [3:0] cmd, int unsigned bi, int unsigned yi,
                                  int unsigned yv, int unsigned rk);
    in_item_t it;
    it.command    = cmd;
    it.bit_index  = 13'(bi);
    it.byte_index = 10'(yi);
    it.byte_value = 8'(yv);
    it.rank       = 13'(rk);
    return it;
  endfunction

  function automatic logic [3:0] pick_command();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 12) return CmdTest;
    if (r < 24) return CmdSet;
    if (r < 32) return CmdClear;
    if (r < 34) return CmdSetAll;
    if (r < 36) return CmdClearAll;
    if (r < 38) return CmdInvert;
    if (r < 48) return CmdLoad;
    if (r < 58) return CmdOr;
    if (r < 66) return CmdAnd;
    if (r < 74) return CmdExcept;
    if (r < 84) return CmdRead;
    if (r < 97) return CmdSelect;
    return 4'($urandom_range(CmdUnusedLast, CmdUnusedFirst));
  endfunction

  // mostly in-range indexes and ranks, the rest anywhere in the field
  function automatic in_item_t random_item();
    in_item_t it;
    it = mk(pick_command(), $urandom_range(8191), $urandom_range(1023),
            $urandom_range(255), $urandom_range(8191));
    if ($urandom_range(99) < 85) begin
      it.bit_index  = 13'($urandom_range(mirror.width_bits - 1));
      it.byte_index = 10'($urandom_range(mirror.byte_span() - 1));
      if (mirror.ones_total != 0) it.rank = 13'($urandom_range(mirror.ones_total - 1));
    end
    return it;
  endfunction

  task automatic send(input in_item_t it);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    mirror.note_command(it);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (mirror.expected_resp.size() != 0) @(negedge clk_i);
  endtask

  task automatic configure(input logic [13:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    mirror.resize(v);
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // full-size map: field extremes and every command
    send(mk(CmdTest, 0, 0, 0, 0));
    send(mk(CmdSet, 8191, 0, 0, 0));
    send(mk(CmdSet, 0, 0, 0, 0));
    send(mk(CmdTest, 8191, 0, 0, 0));
    send(mk(CmdSelect, 0, 0, 0, 1));
    send(mk(CmdSelect, 0, 0, 0, 2));
    send(mk(CmdClear, 8191, 0, 0, 0));
    send(mk(CmdLoad, 0, 1023, 8'hff, 0));
    send(mk(CmdOr, 0, 0, 8'h5a, 0));
    send(mk(CmdAnd, 0, 0, 8'h0f, 0));
    send(mk(CmdExcept, 0, 1023, 8'h0f, 0));
    send(mk(CmdRead, 0, 1023, 0, 0));
    send(mk(CmdInvert, 0, 0, 0, 0));
    send(mk(CmdSetAll, 0, 0, 0, 0));
    send(mk(CmdSelect, 0, 0, 0, 8191));
    send(mk(CmdClearAll, 0, 0, 0, 0));
    send(mk(CmdUnusedFirst, 0, 0, 0, 0));
    send(mk(CmdUnusedLast, 8191, 1023, 8'hff, 8191));
    drain();

    // partial last byte: pad bits stay clear
    configure(14'd13);
    send(mk(CmdSet, 12, 0, 0, 0));
    send(mk(CmdSet, 13, 0, 0, 0));
    send(mk(CmdLoad, 0, 1, 8'hff, 0));
    send(mk(CmdRead, 0, 2, 0, 0));
    send(mk(CmdSetAll, 0, 0, 0, 0));
    send(mk(CmdInvert, 0, 0, 0, 0));
    drain();

    foreach (phase_size[p]) begin
      if (p < 4) begin
        send_idle = 22;
        recv_idle = 65;
      end else if (p < 8) begin
        send_idle = 65;
        recv_idle = 22;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      configure(14'(phase_size[p]));
      if (p == 8) hold_tog <= ~hold_tog;
      repeat (PhaseItems) send(random_item());
      drain();
    end

    repeat (TailCycles) @(negedge clk_i);
    if (mirror.expected_resp.size() != 0)
      mirror.report("items still expected", mirror.expected_resp.size(), 0);
    if (mirror.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #100000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
